[rtl/rimt_pkg.sv]
// ----------------------------------------------------------------------------
// rimt_pkg: shared types and constants of the record identity match table
// Operation and status codes, controller states, cell control bundle and
// the count saturation helper.
// ----------------------------------------------------------------------------
package rimt_pkg;

	localparam int RIMT_DEPTH    = 256;
	localparam int RIMT_TAG_BITS = 16;
	localparam int FILE_TAG_W    = 16;
	localparam int OFFSET_W      = 32;
	localparam int LENGTH_W      = 16;
	localparam int DATE_W        = 32;
	localparam int HASH_W        = 32;
	localparam int OUT_CNT_W     = 9;
	localparam int CNT_MAX_W     = 13;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_REPORT = 2'd2,
		OP_CLEAR  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic {
		CTL_IDLE,
		CTL_EXEC
	} ctl_state_t;

	// Broadcast to every cell in the execute cycle
	typedef struct packed {
		logic clear;
		logic mark;
	} cell_ctl_t;

	// Clamp a count to the 9-bit result fields
	function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [CNT_MAX_W-1:0] v);
		logic [CNT_MAX_W-1:0] lim;
		lim = CNT_MAX_W'((1 << OUT_CNT_W) - 1);
		if (v > lim) begin
			sat_count = lim[OUT_CNT_W-1:0];
		end else begin
			sat_count = v[OUT_CNT_W-1:0];
		end
	endfunction

endpackage

[rtl/rimt_cell.sv]
// ----------------------------------------------------------------------------
// rimt_cell: one table entry
// Holds a key with its valid and referenced bits, compares the incoming key
// and registers the hit for the execute cycle.
// ----------------------------------------------------------------------------
module rimt_cell
	import rimt_pkg::*;
#(
	parameter int KEY_W = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [KEY_W-1:0] cmp_key,
	input  logic [KEY_W-1:0] wr_key,
	input  logic             write,
	input  cell_ctl_t        ctl,
	output logic             hit,
	output logic             fresh
);

	logic [KEY_W-1:0] key_q;
	logic             valid_q;
	logic             marked_q;
	logic             hit_s1;

	// key store needs no reset: valid_q guards every read
	always_ff @(posedge clk) begin
		if (write) begin
			key_q <= wr_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			marked_q <= 1'b0;
			hit_s1   <= 1'b0;
		end else begin
			if (load) begin
				hit_s1 <= valid_q && (key_q == cmp_key);
			end
			if (ctl.clear) begin
				valid_q  <= 1'b0;
				marked_q <= 1'b0;
			end else if (write) begin
				valid_q  <= 1'b1;
				marked_q <= 1'b0;
			end else if (ctl.mark && hit_s1) begin
				marked_q <= 1'b1;
			end
		end
	end

	assign hit   = hit_s1;
	assign fresh = hit_s1 && !marked_q;

endmodule

[rtl/rimt_reduce.sv]
// ----------------------------------------------------------------------------
// rimt_reduce: hit summary over the cell row
// Folds the per-cell hit and unreferenced-hit flags into two flags.
// ----------------------------------------------------------------------------
module rimt_reduce
	import rimt_pkg::*;
#(
	parameter int DEPTH = RIMT_DEPTH
) (
	input  logic [DEPTH-1:0] hit,
	input  logic [DEPTH-1:0] fresh,
	output logic             any_hit,
	output logic             any_fresh
);

	assign any_hit   = |hit;
	assign any_fresh = |fresh;

endmodule

[rtl/record_identity_match_table_unit.sv]
// ----------------------------------------------------------------------------
// record_identity_match_table_unit: associative table of record identities
// A row of entry cells holding file tag, offset, length, date and hash, each
// with a referenced mark. Insert, lookup-and-mark, report and clear requests
// give one result request each.
// ----------------------------------------------------------------------------
//
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  in      | in_valid, in_stall, opcode, file_tag,             | request in
//          | record_offset, record_length, record_date,        |
//          | record_hash                                       |
//  out     | out_valid, out_stall, matched, status,            | result out
//          | live_entries, unreferenced_entries                |
//
// Each request is accepted, then executed: in the accept cycle every cell
// compares its stored key with the incoming one and registers the hit; in
// the execute cycle the hits are folded, the table and counts are updated
// and the result is loaded into the output register. The next request is
// taken in the cycle after execute, not while one still waits to execute.
// Reset empties the table at once (valid and mark bits are flops).
// A stalled result holds in the output register; a new request is still
// taken behind it, but its execute cycle waits until the register is free.
// ----------------------------------------------------------------------------
module record_identity_match_table_unit
	import rimt_pkg::*;
#(
	parameter int TABLE_DEPTH = RIMT_DEPTH,
	parameter int TAG_BITS    = RIMT_TAG_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            opcode,
	input  logic [FILE_TAG_W-1:0] file_tag,
	input  logic [OFFSET_W-1:0]   record_offset,
	input  logic [LENGTH_W-1:0]   record_length,
	input  logic [DATE_W-1:0]     record_date,
	input  logic [HASH_W-1:0]     record_hash,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  matched,
	output logic [1:0]            status,
	output logic [OUT_CNT_W-1:0]  live_entries,
	output logic [OUT_CNT_W-1:0]  unreferenced_entries
);

	// only the low TAG_BITS of the file tag take part, at most the port width
	localparam int KEY_TAG_W = (TAG_BITS < FILE_TAG_W) ? TAG_BITS : FILE_TAG_W;
	localparam int KEY_W     = KEY_TAG_W + OFFSET_W + LENGTH_W + DATE_W + HASH_W;
	localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);

	ctl_state_t          state_q, state_d;
	logic                accept;
	logic                go;

	opcode_t             op_s1;
	logic [KEY_W-1:0]    key_in;
	logic [KEY_W-1:0]    key_s1;

	logic [CNT_W-1:0]    live_q, live_d;
	logic [CNT_W-1:0]    marked_q, marked_d;

	logic [TABLE_DEPTH-1:0] cell_hit;
	logic [TABLE_DEPTH-1:0] cell_fresh;
	logic [TABLE_DEPTH-1:0] cell_write;
	logic                   any_hit;
	logic                   any_fresh;
	cell_ctl_t              ctl;

	logic                do_write;
	logic                table_full;
	logic                matched_d;
	status_t             status_d;
	logic [CNT_W-1:0]    unref_d;

	logic                out_valid_q;
	logic                matched_q;
	logic [1:0]          status_q;
	logic [OUT_CNT_W-1:0] live_out_q;
	logic [OUT_CNT_W-1:0] unref_out_q;

	assign key_in = {file_tag[KEY_TAG_W-1:0], record_offset, record_length,
		record_date, record_hash};

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		accept   = 1'b0;
		go       = 1'b0;
		unique case (state_q)
			CTL_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
				if (in_valid) begin
					state_d = CTL_EXEC;
				end
			end
			CTL_EXEC: begin
				// execute only when the output register can take the result
				go = !out_valid_q || !out_stall;
				if (go) begin
					state_d = CTL_IDLE;
				end
			end
			default: begin
				state_d = CTL_IDLE;
			end
		endcase
	end

	// hold the request for the execute cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= opcode_t'(opcode);
			key_s1 <= key_in;
		end
	end

	// ---------------------------------------------------------------- cell row
	// Entries are only ever added at the lowest free slot and only removed
	// all at once, so the valid entries always form a prefix and the free
	// slot to fill is the one numbered by the live count.
	assign table_full = (live_q == CNT_W'(TABLE_DEPTH));
	assign do_write   = go && (op_s1 == OP_INSERT) && !any_hit && !table_full;
	assign ctl.clear  = go && (op_s1 == OP_CLEAR);
	assign ctl.mark   = go && (op_s1 == OP_LOOKUP);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		assign cell_write[i] = do_write && (live_q == CNT_W'(i));

		rimt_cell #(
			.KEY_W (KEY_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.load    (accept),
			.cmp_key (key_in),
			.wr_key  (key_s1),
			.write   (cell_write[i]),
			.ctl     (ctl),
			.hit     (cell_hit[i]),
			.fresh   (cell_fresh[i])
		);
	end

	rimt_reduce #(
		.DEPTH (TABLE_DEPTH)
	) u_reduce (
		.hit       (cell_hit),
		.fresh     (cell_fresh),
		.any_hit   (any_hit),
		.any_fresh (any_fresh)
	);

	// ---------------------------------------------------------------- execute
	always_comb begin
		live_d    = live_q;
		marked_d  = marked_q;
		matched_d = 1'b0;
		status_d  = ST_DONE;
		case (op_s1)
			OP_INSERT: begin
				// duplicate check comes before the full check
				if (any_hit) begin
					status_d = ST_DUP;
				end else if (table_full) begin
					status_d = ST_FULL;
				end else begin
					live_d = live_q + CNT_W'(1);
				end
			end
			OP_LOOKUP: begin
				matched_d = any_hit;
				if (any_fresh) begin
					marked_d = marked_q + CNT_W'(1);
				end
			end
			OP_CLEAR: begin
				live_d   = '0;
				marked_d = '0;
			end
			default: begin
				// report: counts only
			end
		endcase
	end

	// marks never outnumber live entries
	assign unref_d = live_d - marked_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q   <= '0;
			marked_q <= '0;
		end else if (go) begin
			live_q   <= live_d;
			marked_q <= marked_d;
		end
	end

	// ---------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			matched_q   <= matched_d;
			status_q    <= status_d;
			live_out_q  <= sat_count(CNT_MAX_W'(live_d));
			unref_out_q <= sat_count(CNT_MAX_W'(unref_d));
		end
	end

	assign out_valid            = out_valid_q;
	assign matched              = matched_q;
	assign status               = status_q;
	assign live_entries         = live_out_q;
	assign unreferenced_entries = unref_out_q;

endmodule
